// File: design/eitx_pkg.sv
// Shared types and constants for the Ethernet/IPv4/TCP header extractor.
`timescale 1ns / 1ps
`default_nettype none

package eitx_pkg;

  localparam int ByteW     = 8;
  localparam int MacW      = 48;
  localparam int IpW       = 32;
  localparam int PortW     = 16;
  localparam int LimitW    = 6;
  localparam int PosW      = 16;
  localparam int IndexW    = 5;

  localparam logic [LimitW-1:0] MaxDump     = 6'd32;
  localparam logic [5:0]        MinHdrBytes = 6'd20;
  localparam logic [PosW-1:0]   PosMax      = 16'hFFFF;

  localparam logic [15:0] EthIpv4 = 16'h0800;
  localparam logic [15:0] EthArp  = 16'h0806;
  localparam logic [15:0] EthIpv6 = 16'h86DD;

  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;
  localparam logic [7:0] ProtoSctp = 8'd132;

  // item_kind codes
  localparam logic [1:0] KindSummary = 2'd0;
  localparam logic [1:0] KindPayload = 2'd1;
  localparam logic [1:0] KindTrunc   = 2'd2;

  // network_kind codes
  localparam logic [1:0] NetIpv4  = 2'd0;
  localparam logic [1:0] NetArp   = 2'd1;
  localparam logic [1:0] NetIpv6  = 2'd2;
  localparam logic [1:0] NetOther = 2'd3;

  // transport_kind codes
  localparam logic [2:0] TrTcp   = 3'd0;
  localparam logic [2:0] TrUdp   = 3'd1;
  localparam logic [2:0] TrSctp  = 3'd2;
  localparam logic [2:0] TrOther = 3'd3;
  localparam logic [2:0] TrNone  = 3'd4;

  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic             frame_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        item_kind;
    logic [MacW-1:0]   dest_mac;
    logic [MacW-1:0]   source_mac;
    logic [1:0]        network_kind;
    logic [IpW-1:0]    source_ip;
    logic [IpW-1:0]    dest_ip;
    logic [2:0]        transport_kind;
    logic [PortW-1:0]  source_port;
    logic [PortW-1:0]  dest_port;
    logic [ByteW-1:0]  payload_byte;
    logic [IndexW-1:0] payload_index;
    logic              run_last;
  } out_item_t;

endpackage

`default_nettype wire

// File: design/eth_ipv4_tcp_header_extractor.sv
// Top level: Ethernet/IPv4/TCP header extractor with byte-wide frame input.
// Each result lands in the result register, or in the skid stage while that is held.
// Throughput: one frame byte per cycle while in_stall is low; the capture/classify
// logic sits between the per-frame state registers and the result register; a skid
// stage keeps in_stall registered, set only when both result slots are occupied.
// Reset (synchronous, rst_n low): frame state cleared, payload limit set to 32.
`timescale 1ns / 1ps
`default_nettype none

module eth_ipv4_tcp_header_extractor (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  eitx_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output eitx_pkg::out_item_t          out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [eitx_pkg::LimitW-1:0]   cfg_data
);
  import eitx_pkg::*;

  logic      in_fire;
  logic      res_valid;
  out_item_t res_item;
  logic      buf_full;

  assign in_stall = buf_full;
  assign in_fire  = in_valid && !in_stall;

  eitx_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  eitx_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_item (res_item),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: design/eitx_parse.sv
// Per-frame header capture, classification and result generation.
`timescale 1ns / 1ps
`default_nettype none

module eitx_parse (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_fire,
  input  eitx_pkg::in_item_t           in_item,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [eitx_pkg::LimitW-1:0]   cfg_data,
  output logic                         res_valid,
  output eitx_pkg::out_item_t          res_item
);
  import eitx_pkg::*;

  logic [LimitW-1:0] limit_r;

  logic [PosW-1:0]   pos_r, pos_nxt;
  logic [MacW-1:0]   dmac_r, dmac_nxt;
  logic [MacW-1:0]   smac_r, smac_nxt;
  logic [15:0]       etype_r, etype_nxt;
  logic [IpW-1:0]    sip_r, sip_nxt;
  logic [IpW-1:0]    dip_r, dip_nxt;
  logic [7:0]        proto_r, proto_nxt;
  logic [5:0]        iphb_r, iphb_nxt;
  logic [PortW-1:0]  sport_r, sport_nxt;
  logic [PortW-1:0]  dport_r, dport_nxt;
  logic [7:0]        poff_r, poff_nxt;
  logic [LimitW-1:0] emitted_r, emitted_nxt;
  logic              sum_done_r, sum_done_nxt;

  logic [ByteW-1:0]  b;
  logic              last;
  logic [PosW-1:0]   tcp_start;
  logic [5:0]        hdr_len;
  logic [5:0]        doff;
  logic              ipv4;
  logic              tcp;
  logic              due;
  logic [LimitW-1:0] lim;
  logic              rv;
  out_item_t         item;

  assign cfg_ready = 1'b1;
  assign b         = in_item.frame_byte;
  assign last      = in_item.frame_end;
  assign lim       = (limit_r > MaxDump) ? MaxDump : limit_r;
  assign tcp_start = PosW'(7'd14 + {1'b0, iphb_r});

  // Capture: applies to this byte only while the summary is still pending.
  always_comb begin
    dmac_nxt  = dmac_r;
    smac_nxt  = smac_r;
    etype_nxt = etype_r;
    sip_nxt   = sip_r;
    dip_nxt   = dip_r;
    proto_nxt = proto_r;
    iphb_nxt  = iphb_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    poff_nxt  = poff_r;
    hdr_len   = {b[3:0], 2'b00};
    doff      = {b[7:4], 2'b00};
    if (!sum_done_r) begin
      if (pos_r < 16'd6) begin
        dmac_nxt = {dmac_r[MacW-9:0], b};
      end else if (pos_r < 16'd12) begin
        smac_nxt = {smac_r[MacW-9:0], b};
      end else if (pos_r < 16'd14) begin
        etype_nxt = {etype_r[7:0], b};
      end else if (etype_r == EthIpv4) begin
        if (pos_r == 16'd14) begin
          iphb_nxt = (hdr_len < MinHdrBytes) ? MinHdrBytes : hdr_len;
        end else if (pos_r == 16'd23) begin
          proto_nxt = b;
        end else if (pos_r >= 16'd26 && pos_r < 16'd30) begin
          sip_nxt = {sip_r[IpW-9:0], b};
        end else if (pos_r >= 16'd30 && pos_r < 16'd34) begin
          dip_nxt = {dip_r[IpW-9:0], b};
        end else if (proto_r == ProtoTcp && pos_r >= tcp_start) begin
          if (pos_r < tcp_start + 16'd2) begin
            sport_nxt = {sport_r[7:0], b};
          end else if (pos_r < tcp_start + 16'd4) begin
            dport_nxt = {dport_r[7:0], b};
          end else if (pos_r == tcp_start + 16'd12) begin
            poff_nxt = tcp_start[7:0] +
                       {2'b00, ((doff < MinHdrBytes) ? MinHdrBytes : doff)};
          end
        end
      end
    end
  end

  assign ipv4 = (etype_nxt == EthIpv4);
  assign tcp  = ipv4 && (proto_nxt == ProtoTcp);

  always_comb begin
    if (!ipv4) begin
      due = (pos_r >= 16'd13);
    end else if (!tcp) begin
      due = (pos_r >= 16'd33);
    end else begin
      due = (poff_nxt != 8'd0) && (({1'b0, pos_r} + 17'd1) >= {9'd0, poff_nxt});
    end
  end

  // Result item and per-frame bookkeeping.
  always_comb begin
    item                = '0;
    item.dest_mac       = dmac_nxt;
    item.source_mac     = smac_nxt;
    item.network_kind   = NetOther;
    item.transport_kind = TrNone;
    if (etype_nxt == EthIpv4) begin
      item.network_kind = NetIpv4;
    end else if (etype_nxt == EthArp) begin
      item.network_kind = NetArp;
    end else if (etype_nxt == EthIpv6) begin
      item.network_kind = NetIpv6;
    end
    if (ipv4) begin
      item.source_ip = sip_nxt;
      item.dest_ip   = dip_nxt;
      if (proto_nxt == ProtoTcp) begin
        item.transport_kind = TrTcp;
      end else if (proto_nxt == ProtoUdp) begin
        item.transport_kind = TrUdp;
      end else if (proto_nxt == ProtoSctp) begin
        item.transport_kind = TrSctp;
      end else begin
        item.transport_kind = TrOther;
      end
    end
    if (tcp) begin
      item.source_port = sport_nxt;
      item.dest_port   = dport_nxt;
    end

    rv           = 1'b0;
    sum_done_nxt = sum_done_r;
    emitted_nxt  = emitted_r;
    if (!sum_done_r) begin
      if (due || last) begin
        item.item_kind = due ? KindSummary : KindTrunc;
        item.run_last  = last || !tcp || (lim == '0);
        rv             = 1'b1;
        sum_done_nxt   = 1'b1;
      end
    end else if (tcp && emitted_r < lim) begin
      item.item_kind     = KindPayload;
      item.payload_byte  = b;
      item.payload_index = emitted_r[IndexW-1:0];
      item.run_last      = last || (({1'b0, emitted_r} + 7'd1) >= {1'b0, lim});
      rv                 = 1'b1;
      emitted_nxt        = emitted_r + 6'd1;
    end
  end

  assign pos_nxt   = (pos_r < PosMax) ? pos_r + 16'd1 : pos_r;
  assign res_valid = in_fire && rv;
  assign res_item  = item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= MaxDump;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && last)) begin
      pos_r      <= '0;
      dmac_r     <= '0;
      smac_r     <= '0;
      etype_r    <= '0;
      sip_r      <= '0;
      dip_r      <= '0;
      proto_r    <= '0;
      iphb_r     <= MinHdrBytes;
      sport_r    <= '0;
      dport_r    <= '0;
      poff_r     <= '0;
      emitted_r  <= '0;
      sum_done_r <= 1'b0;
    end else if (in_fire) begin
      pos_r      <= pos_nxt;
      dmac_r     <= dmac_nxt;
      smac_r     <= smac_nxt;
      etype_r    <= etype_nxt;
      sip_r      <= sip_nxt;
      dip_r      <= dip_nxt;
      proto_r    <= proto_nxt;
      iphb_r     <= iphb_nxt;
      sport_r    <= sport_nxt;
      dport_r    <= dport_nxt;
      poff_r     <= poff_nxt;
      emitted_r  <= emitted_nxt;
      sum_done_r <= sum_done_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/eitx_out_buf.sv
// Result register with a skid stage so the input side sees a registered stall.
`timescale 1ns / 1ps
`default_nettype none

module eitx_out_buf (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  eitx_pkg::out_item_t   push_item,
  output logic                  full,
  output logic                  out_valid,
  input  wire                   out_stall,
  output eitx_pkg::out_item_t   out_data
);
  import eitx_pkg::*;

  logic      main_valid_r;
  logic      skid_valid_r;
  out_item_t main_r;
  out_item_t skid_r;
  logic      out_fire;
  logic      main_free;

  assign out_fire  = main_valid_r && !out_stall;
  assign main_free = !main_valid_r || out_fire;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (main_free) begin
        // refill from skid first; no push can arrive while skid holds a transaction
        main_valid_r <= skid_valid_r || push;
        skid_valid_r <= 1'b0;
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_r <= skid_valid_r ? skid_r : push_item;
    end
    if (!main_free && push) begin
      skid_r <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: sim/eth_ipv4_tcp_header_extractor_tb.sv
// Self-checking testbench for the Ethernet/IPv4/TCP header extractor.
`timescale 1ns / 1ps

module eth_ipv4_tcp_header_extractor_tb;
  import eitx_pkg::*;

  localparam int QuietLimit = 5000;
  localparam int DrainLimit = 2000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [LimitW-1:0] cfg_data = '0;

  eth_ipv4_tcp_header_extractor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  in_item_t  bytes_to_send[$];
  out_item_t results_due[$];

  logic calm = 1'b0;
  logic rx_hold = 1'b0;
  logic pressure_go = 1'b0;

  int errors = 0;
  int n_frames = 0;
  int n_bytes_queued = 0;
  int n_results = 0;
  int n_summary = 0;
  int n_trunc = 0;
  int n_payload = 0;
  int n_cfg = 0;
  int quiet_cycles = 0;

  // Frame parser state, mirrored from the block
  logic [LimitW-1:0] dump_limit = MaxDump;
  logic [PosW-1:0]   fp_pos;
  logic [MacW-1:0]   fp_dmac;
  logic [MacW-1:0]   fp_smac;
  logic [15:0]       fp_etype;
  logic [IpW-1:0]    fp_sip;
  logic [IpW-1:0]    fp_dip;
  logic [7:0]        fp_proto;
  logic [5:0]        fp_ip_len;
  logic [PortW-1:0]  fp_sport;
  logic [PortW-1:0]  fp_dport;
  logic [7:0]        fp_pay_start;
  logic [5:0]        fp_dumped;
  logic              fp_summary_sent;

  function automatic void clear_frame();
    fp_pos = '0;
    fp_dmac = '0;
    fp_smac = '0;
    fp_etype = '0;
    fp_sip = '0;
    fp_dip = '0;
    fp_proto = '0;
    fp_ip_len = MinHdrBytes;
    fp_sport = '0;
    fp_dport = '0;
    fp_pay_start = '0;
    fp_dumped = '0;
    fp_summary_sent = 1'b0;
  endfunction

  function automatic out_item_t header_summary();
    out_item_t h;
    h = '0;
    h.dest_mac = fp_dmac;
    h.source_mac = fp_smac;
    case (fp_etype)
      EthIpv4: h.network_kind = NetIpv4;
      EthArp:  h.network_kind = NetArp;
      EthIpv6: h.network_kind = NetIpv6;
      default: h.network_kind = NetOther;
    endcase
    h.transport_kind = TrNone;
    if (fp_etype == EthIpv4) begin
      h.source_ip = fp_sip;
      h.dest_ip = fp_dip;
      case (fp_proto)
        ProtoTcp: begin
          h.transport_kind = TrTcp;
          h.source_port = fp_sport;
          h.dest_port = fp_dport;
        end
        ProtoUdp:  h.transport_kind = TrUdp;
        ProtoSctp: h.transport_kind = TrSctp;
        default:   h.transport_kind = TrOther;
      endcase
    end
    return h;
  endfunction

  // Advance the parser by one frame byte; return 1 when the byte yields a result.
  function automatic bit parse_frame_byte(input in_item_t it, output out_item_t res);
    logic [7:0] b;
    int p, lim, t, hl;
    bit due, tcp, made;
    b = it.frame_byte;
    p = int'(fp_pos);
    lim = (dump_limit > MaxDump) ? int'(MaxDump) : int'(dump_limit);
    res = '0;
    made = 1'b0;
    if (!fp_summary_sent) begin
      if (p < 6) fp_dmac = {fp_dmac[39:0], b};
      else if (p < 12) fp_smac = {fp_smac[39:0], b};
      else if (p < 14) fp_etype = {fp_etype[7:0], b};
      else if (fp_etype == EthIpv4) begin
        t = 14 + int'(fp_ip_len);
        if (p == 14) begin
          hl = int'(b[3:0]) * 4;
          fp_ip_len = (hl < 20) ? MinHdrBytes : 6'(hl);
        end else if (p == 23) fp_proto = b;
        else if (p >= 26 && p < 30) fp_sip = {fp_sip[23:0], b};
        else if (p >= 30 && p < 34) fp_dip = {fp_dip[23:0], b};
        else if (fp_proto == ProtoTcp && p >= t) begin
          if (p < t + 2) fp_sport = {fp_sport[7:0], b};
          else if (p < t + 4) fp_dport = {fp_dport[7:0], b};
          else if (p == t + 12) begin
            hl = int'(b[7:4]) * 4;
            fp_pay_start = 8'(t + ((hl < 20) ? 20 : hl));
          end
        end
      end
    end
    tcp = (fp_etype == EthIpv4) && (fp_proto == ProtoTcp);
    if (!fp_summary_sent) begin
      if (fp_etype != EthIpv4) due = (p >= 13);
      else if (!tcp) due = (p >= 33);
      else due = (fp_pay_start != 0) && (p + 1 >= int'(fp_pay_start));
      if (due || it.frame_end) begin
        res = header_summary();
        res.item_kind = due ? KindSummary : KindTrunc;
        res.run_last = it.frame_end || !tcp || (lim == 0);
        fp_summary_sent = 1'b1;
        made = 1'b1;
      end
    end else if (tcp && int'(fp_dumped) < lim) begin
      res = header_summary();
      res.item_kind = KindPayload;
      res.payload_byte = b;
      res.payload_index = fp_dumped[IndexW-1:0];
      res.run_last = it.frame_end || (int'(fp_dumped) + 1 >= lim);
      fp_dumped = fp_dumped + 6'd1;
      made = 1'b1;
    end
    if (it.frame_end) clear_frame();
    else if (fp_pos != PosMax) fp_pos = fp_pos + 16'd1;
    return made;
  endfunction

  task automatic report_error(input string msg);
    errors++;
    if (errors <= 30) $display("tb: mismatch at result %0d: %s", n_results, msg);
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.item_kind !== want.item_kind)
      report_error($sformatf("item_kind %0d, want %0d", got.item_kind, want.item_kind));
    if (got.dest_mac !== want.dest_mac)
      report_error($sformatf("dest_mac %h, want %h", got.dest_mac, want.dest_mac));
    if (got.source_mac !== want.source_mac)
      report_error($sformatf("source_mac %h, want %h", got.source_mac, want.source_mac));
    if (got.network_kind !== want.network_kind)
      report_error($sformatf("network_kind %0d, want %0d",
                             got.network_kind, want.network_kind));
    if (got.source_ip !== want.source_ip)
      report_error($sformatf("source_ip %h, want %h", got.source_ip, want.source_ip));
    if (got.dest_ip !== want.dest_ip)
      report_error($sformatf("dest_ip %h, want %h", got.dest_ip, want.dest_ip));
    if (got.transport_kind !== want.transport_kind)
      report_error($sformatf("transport_kind %0d, want %0d",
                             got.transport_kind, want.transport_kind));
    if (got.source_port !== want.source_port)
      report_error($sformatf("source_port %h, want %h", got.source_port, want.source_port));
    if (got.dest_port !== want.dest_port)
      report_error($sformatf("dest_port %h, want %h", got.dest_port, want.dest_port));
    if (got.payload_byte !== want.payload_byte)
      report_error($sformatf("payload_byte %h, want %h", got.payload_byte, want.payload_byte));
    if (got.payload_index !== want.payload_index)
      report_error($sformatf("payload_index %0d, want %0d",
                             got.payload_index, want.payload_index));
    if (got.run_last !== want.run_last)
      report_error($sformatf("run_last %b, want %b", got.run_last, want.run_last));
    case (want.item_kind)
      KindSummary: n_summary++;
      KindTrunc:   n_trunc++;
      default:     n_payload++;
    endcase
  endtask

  // Sender: hold the byte while stalled, otherwise advance or idle.
  always @(posedge clk) begin : feed
    out_item_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (parse_frame_byte(in_data, res)) results_due.push_back(res);
      end
      if (!in_valid || !in_stall) begin
        if (bytes_to_send.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
          in_data <= bytes_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver
  always @(posedge clk) begin : sink
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (results_due.size() == 0) report_error("result with nothing outstanding");
        else check_result(out_data, results_due.pop_front());
      end
      out_stall <= rx_hold || (!calm && $urandom_range(99) < 28);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb: no transaction for %0d cycles", QuietLimit);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin : hold_off
    while (!pressure_go) @(posedge clk);
    repeat (10) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (150) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic queue_bytes(ref logic [7:0] fb[$], input int cut_at);
    in_item_t it;
    int n, i;
    n = (cut_at >= 0 && cut_at < fb.size()) ? cut_at + 1 : fb.size();
    for (i = 0; i < n; i++) begin
      it.frame_byte = fb[i];
      it.frame_end = (i == n - 1);
      bytes_to_send.push_back(it);
    end
    n_bytes_queued += n;
    n_frames++;
  endtask

  // Well-formed frame; cut_at >= 0 ends the frame early at that byte, if the frame is longer.
  task automatic add_frame(input logic [15:0] etype, input logic [3:0] ihl,
                           input logic [7:0] proto, input logic [3:0] doff,
                           input int pay_len, input int cut_at);
    logic [7:0] fb[$];
    int ip_len, tcp_len, i;
    for (i = 0; i < 12; i++) fb.push_back(8'($urandom_range(255)));
    fb.push_back(etype[15:8]);
    fb.push_back(etype[7:0]);
    if (etype == EthIpv4) begin
      ip_len = (int'(ihl) * 4 < 20) ? 20 : int'(ihl) * 4;
      fb.push_back({4'h4, ihl});
      for (i = 15; i < 14 + ip_len; i++)
        fb.push_back((i == 23) ? proto : 8'($urandom_range(255)));
      if (proto == ProtoTcp) begin
        tcp_len = (int'(doff) * 4 < 20) ? 20 : int'(doff) * 4;
        for (i = 0; i < tcp_len; i++)
          fb.push_back((i == 12) ? {doff, 4'($urandom_range(15))} : 8'($urandom_range(255)));
      end
    end
    for (i = 0; i < pay_len; i++) fb.push_back(8'($urandom_range(255)));
    queue_bytes(fb, cut_at);
  endtask

  // Unstructured frame; fill < 0 gives random bytes.
  task automatic add_noise(input int len, input int fill);
    logic [7:0] fb[$];
    int i;
    for (i = 0; i < len; i++) fb.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
    queue_bytes(fb, -1);
  endtask

  task automatic add_random_frame();
    logic [15:0] et;
    logic [7:0] pr;
    logic [3:0] ihl, doff;
    int sel, pay, cut;
    sel = $urandom_range(99);
    if (sel < 12) begin
      add_noise($urandom_range(1, 80), -1);
      return;
    end
    sel = $urandom_range(99);
    et = (sel < 70) ? EthIpv4 : (sel < 78) ? EthArp : (sel < 86) ? EthIpv6 : 16'($urandom);
    sel = $urandom_range(99);
    pr = (sel < 70) ? ProtoTcp : (sel < 78) ? ProtoUdp : (sel < 86) ? ProtoSctp : 8'($urandom);
    ihl = ($urandom_range(99) < 80) ? 4'($urandom_range(5, 7)) : 4'($urandom_range(15));
    doff = ($urandom_range(99) < 80) ? 4'($urandom_range(5, 8)) : 4'($urandom_range(15));
    pay = ($urandom_range(99) < 15) ? $urandom_range(3) : $urandom_range(40);
    cut = ($urandom_range(99) < 15) ? $urandom_range(90) : -1;
    add_frame(et, ihl, pr, doff, pay, cut);
  endtask

  // Wait until every byte is in and every result is out (or DrainLimit runs out), then let the block settle.
  task automatic drain();
    int waited;
    waited = 0;
    while (bytes_to_send.size() != 0 || in_valid) @(posedge clk);
    while (results_due.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] value);
    @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dump_limit = value;
    n_cfg++;
  endtask

  initial begin : stimulus
    in_item_t tail[$];
    int ph, target;
    clear_frame();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset limit
    add_frame(EthIpv4, 4'd5, ProtoTcp, 4'd5, 3, -1);
    add_frame(EthArp, 4'd5, ProtoTcp, 4'd5, 10, -1);
    add_frame(EthIpv6, 4'd5, ProtoTcp, 4'd5, 6, -1);
    add_frame(16'h88CC, 4'd5, ProtoTcp, 4'd5, 2, -1);
    add_frame(EthIpv4, 4'd5, ProtoUdp, 4'd5, 8, -1);
    add_frame(EthIpv4, 4'd6, ProtoSctp, 4'd5, 4, -1);
    add_frame(EthIpv4, 4'd5, 8'hFF, 4'd5, 4, -1);
    add_frame(EthIpv4, 4'd0, ProtoTcp, 4'd0, 4, -1);   // short lengths clamp to 20
    add_frame(EthIpv4, 4'd15, ProtoTcp, 4'd15, 5, -1);
    add_frame(EthIpv4, 4'd5, ProtoTcp, 4'd5, 0, -1);   // summary on the last byte
    add_frame(EthIpv4, 4'd5, ProtoTcp, 4'd5, 40, -1);  // dump caps at 32
    add_noise(1, 255);
    add_noise(13, 0);                                   // ends inside the ethertype
    add_noise(20, 0);
    add_noise(30, 255);
    add_frame(EthIpv4, 4'd5, ProtoTcp, 4'd5, 10, 20);  // ends inside the IP header
    add_frame(EthIpv4, 4'd5, ProtoTcp, 4'd5, 10, 38);  // ends inside the TCP header
    add_frame(EthIpv4, 4'd5, ProtoUdp, 4'd5, 10, 30);
    drain();

    write_limit(6'd0);
    add_frame(EthIpv4, 4'd5, ProtoTcp, 4'd5, 5, -1);
    add_frame(EthIpv4, 4'd7, ProtoTcp, 4'd6, 5, 50);
    drain();
    write_limit(6'd63);
    add_frame(EthIpv4, 4'd5, ProtoTcp, 4'd5, 40, -1);
    drain();
    write_limit(6'd1);
    add_frame(EthIpv4, 4'd5, ProtoTcp, 4'd5, 3, -1);
    add_frame(EthIpv4, 4'd5, ProtoTcp, 4'd5, 1, -1);
    drain();

    // Lower the limit below the bytes already dumped in the middle of a frame
    write_limit(6'd32);
    add_frame(EthIpv4, 4'd5, ProtoTcp, 4'd5, 20, -1);
    while (bytes_to_send.size() > 60) tail.push_front(bytes_to_send.pop_back());
    drain();
    write_limit(6'd3);
    while (tail.size() != 0) bytes_to_send.push_back(tail.pop_front());
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       write_limit(6'd32);
        1:       write_limit(6'd63);
        2:       write_limit(6'd0);
        3:       write_limit(6'($urandom_range(1, 31)));
        4:       write_limit(6'd1);
        default: write_limit(6'($urandom_range(63)));
      endcase
      calm <= (ph == 1);
      pressure_go <= (ph == 3);
      // the no-idle and back-pressure phases get a longer run of bytes
      target = n_bytes_queued + ((ph == 1) ? 60 : (ph == 3) ? 80 : 1);
      while (n_bytes_queued < target) add_random_frame();
      drain();
    end
    calm <= 1'b0;

    repeat (8) @(posedge clk);
    if (results_due.size() != 0)
      report_error($sformatf("%0d results never arrived", results_due.size()));
    $display("tb: %0d frames, %0d bytes, %0d limit writes, %0d mismatches",
             n_frames, n_bytes_queued, n_cfg, errors);
    $display("tb: results %0d summaries, %0d truncated, %0d payload bytes",
             n_summary, n_trunc, n_payload);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
design/eitx_pkg.sv
design/eitx_parse.sv
design/eitx_out_buf.sv
design/eth_ipv4_tcp_header_extractor.sv
sim/eth_ipv4_tcp_header_extractor_tb.sv
